// ----- rtl/core/tlrb_pkg.sv -----
package tlrb_pkg;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_POSITION = 3'd1,
    OP_READ = 3'd2,
    OP_CLEAR = 3'd3,
    OP_STATS = 3'd4
  } op_e;

  localparam logic [1:0] KIND_ACK = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_STATS = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Ring size; pointer wrap and the fill percentage rely on a power of two
  localparam int unsigned StoreBytes = 4096;
  localparam int unsigned HdrBytes = 5;
  localparam int unsigned LenOffset = 4;   // length byte within the header
  localparam int unsigned MaxResults = 64;
  localparam logic [9:0] CountLimit = 10'd1023;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_byte;
    logic last;
    logic [31:0] time_stamp;
    logic [9:0] latest_count;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
    logic [31:0] rec_time;
    logic [7:0] rec_byte;
    logic end_of_run;
    logic [9:0] entries_now;
    logic [31:0] writes_total;
    logic [31:0] drops_total;
    logic [9:0] entries_peak;
    logic [6:0] fill_percent;
  } out_word_t;

  // Commands from the controller to the datapath
  typedef enum logic [3:0] {
    CMD_NONE = 4'd0,
    CMD_STAGE = 4'd1,
    CMD_EVICT = 4'd2,
    CMD_WRITE = 4'd3,
    CMD_COMMIT_END = 4'd4,
    CMD_SKIP_RD = 4'd5,
    CMD_SKIP = 4'd6,
    CMD_POS_SET = 4'd7,
    CMD_RD_HDR = 4'd8,
    CMD_RD_LEN = 4'd9,
    CMD_RD_BYTE = 4'd10,
    CMD_READ_END = 4'd11,
    CMD_CLEAR = 4'd12
  } cmd_e;

  typedef struct packed {
    logic need_evict;   // must evict before commit
    logic fits;         // record fits now
    logic write_done;   // last byte of the record written
    logic no_records;
    logic skip_done;    // cursor skip finished
    logic cursor_empty;
    logic hdr_done;     // last timestamp byte being taken
    logic bytes_done;   // nothing more to emit
    logic byte_last;    // byte now fetched is the final emitted one
    logic len_zero;
  } dp_status_t;

endpackage

// ----- rtl/core/tlrb_if.sv -----
interface tlrb_in_if;
  import tlrb_pkg::*;
  logic valid;
  logic ready;
  in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tlrb_out_if;
  import tlrb_pkg::*;
  logic valid;
  logic ready;
  out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/core/tlrb_datapath.sv -----
module tlrb_datapath #(
  parameter int unsigned MSG_MAX = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  tlrb_pkg::cmd_e cmd_i,
  input  tlrb_pkg::in_word_t in_word_i,
  output tlrb_pkg::dp_status_t status_o,
  output logic [31:0] rec_time_o,
  output logic [7:0] rec_byte_o,
  output tlrb_pkg::out_word_t stats_o
);
  import tlrb_pkg::*;

  localparam int unsigned AW = $clog2(StoreBytes);
  localparam int unsigned SW = $clog2(MSG_MAX + 1);
  localparam int unsigned IW = (MSG_MAX > 1) ? $clog2(MSG_MAX) : 1;
  localparam int unsigned PW = AW + 7;

  logic [7:0] log_mem [StoreBytes];
  logic [7:0] stage_mem [MSG_MAX];

  logic [AW-1:0] head_q, tail_q, cur_q, ptr_q, ptr_d;
  logic [AW-1:0] tail_next, cur_next;
  logic [9:0] count_q, left_q, peak_q, skip_q;
  logic [31:0] writes_q, drops_q, time_q, stamp_q;
  logic [SW-1:0] slen_q;
  logic [8:0] wi_q;   // write step index: 0..4 header, then message
  logic [7:0] len_q;
  logic [7:0] bi_q;   // read step index
  logic [7:0] rd_q;   // always the byte at ptr_q
  logic [7:0] srd_q;
  logic [AW:0] used, free_b;
  logic [PW-1:0] prod_q;

  assign used = (head_q >= tail_q) ? {1'b0, head_q - tail_q}
                                   : (AW+1)'(StoreBytes) - {1'b0, tail_q - head_q};
  assign free_b = (AW+1)'(StoreBytes - 1) - used;

  logic [AW:0] need;
  assign need = (AW+1)'(HdrBytes) + (AW+1)'(slen_q);

  // start of the record after the one whose length byte sits in rd_q
  assign tail_next = AW'(tail_q + AW'(HdrBytes) + AW'(rd_q));
  assign cur_next = AW'(cur_q + AW'(HdrBytes) + AW'(rd_q));

  always_comb begin
    status_o.need_evict = (count_q != 10'd0) && ((free_b < need) || (count_q >= CountLimit));
    status_o.fits = free_b >= need;
    status_o.write_done = wi_q == 9'(HdrBytes) + 9'(slen_q) - 9'd1;
    status_o.no_records = count_q == 10'd0;
    status_o.skip_done = skip_q == 10'd0;
    status_o.cursor_empty = left_q == 10'd0;
    status_o.hdr_done = bi_q == 8'(LenOffset - 1);
    status_o.bytes_done = (bi_q >= len_q) || (bi_q >= 8'(MaxResults));
    status_o.byte_last = (bi_q == len_q - 8'd1) || (bi_q == 8'(MaxResults - 1));
    status_o.len_zero = len_q == 8'd0;
  end

  // Byte at write step index
  logic [7:0] wbyte;
  always_comb begin
    case (wi_q)
      9'd0: wbyte = stamp_q[7:0];
      9'd1: wbyte = stamp_q[15:8];
      9'd2: wbyte = stamp_q[23:16];
      9'd3: wbyte = stamp_q[31:24];
      9'd4: wbyte = 8'(slen_q);
      default: wbyte = srd_q;
    endcase
  end

  logic [9:0] want;
  assign want = (in_word_i.latest_count == 10'd0 || in_word_i.latest_count > count_q)
                ? count_q : in_word_i.latest_count;

  // Read pointer; the registered read keeps rd_q at the byte under ptr_q
  always_comb begin
    ptr_d = ptr_q;
    case (cmd_i)
      CMD_STAGE: ptr_d = AW'(tail_q + AW'(LenOffset));
      CMD_EVICT: ptr_d = AW'(tail_next + AW'(LenOffset));
      CMD_SKIP_RD: ptr_d = AW'(tail_q + AW'(LenOffset));
      CMD_SKIP: ptr_d = AW'(cur_next + AW'(LenOffset));
      CMD_POS_SET: ptr_d = cur_q;
      CMD_RD_HDR, CMD_RD_LEN, CMD_RD_BYTE: ptr_d = AW'(ptr_q + AW'(1));
      default: ptr_d = ptr_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_q <= log_mem[ptr_d];
    srd_q <= stage_mem[IW'(wi_q - 9'd4)];
    if (cmd_i == CMD_STAGE && slen_q < SW'(MSG_MAX))
      stage_mem[IW'(slen_q)] <= in_word_i.data_byte;
    if (cmd_i == CMD_WRITE) log_mem[AW'(head_q + AW'(wi_q))] <= wbyte;
    prod_q <= PW'(used) * PW'(100);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0; tail_q <= '0; cur_q <= '0; ptr_q <= '0;
      count_q <= '0; left_q <= '0; peak_q <= '0; skip_q <= '0;
      writes_q <= '0; drops_q <= '0; slen_q <= '0;
      wi_q <= '0; bi_q <= '0; len_q <= '0; time_q <= '0; stamp_q <= '0;
    end else begin
      ptr_q <= ptr_d;
      case (cmd_i)
        CMD_STAGE: begin
          if (slen_q < SW'(MSG_MAX)) slen_q <= SW'(slen_q + SW'(1));
          if (in_word_i.last) left_q <= '0;
          stamp_q <= in_word_i.time_stamp;
          wi_q <= '0;
        end
        CMD_EVICT: begin
          tail_q <= tail_next;
          count_q <= count_q - 10'd1;
          drops_q <= drops_q + 32'd1;
        end
        CMD_WRITE: wi_q <= wi_q + 9'd1;
        CMD_COMMIT_END: begin
          if (free_b >= need) begin
            head_q <= AW'(head_q + AW'(need));
            count_q <= count_q + 10'd1;
            writes_q <= writes_q + 32'd1;
            if (count_q + 10'd1 > peak_q) peak_q <= count_q + 10'd1;
          end
          slen_q <= '0;
          wi_q <= '0;
        end
        CMD_SKIP_RD: begin
          if (count_q != 10'd0) skip_q <= count_q - want;
          cur_q <= tail_q;
          left_q <= (count_q == 10'd0) ? 10'd0 : want;
        end
        CMD_SKIP: begin
          cur_q <= cur_next;
          skip_q <= skip_q - 10'd1;
        end
        CMD_POS_SET: bi_q <= '0;
        CMD_RD_HDR: begin
          case (bi_q)
            8'd0: time_q[7:0] <= rd_q;
            8'd1: time_q[15:8] <= rd_q;
            8'd2: time_q[23:16] <= rd_q;
            8'd3: time_q[31:24] <= rd_q;
            default: ;
          endcase
          bi_q <= bi_q + 8'd1;
        end
        CMD_RD_LEN: begin
          len_q <= rd_q;
          bi_q <= '0;
        end
        CMD_RD_BYTE: bi_q <= bi_q + 8'd1;
        CMD_READ_END: begin
          cur_q <= AW'(cur_q + AW'(HdrBytes) + AW'(len_q));
          left_q <= left_q - 10'd1;
          bi_q <= '0;
        end
        CMD_CLEAR: begin
          head_q <= '0; tail_q <= '0; count_q <= '0; left_q <= '0;
        end
        default: ;
      endcase
    end
  end

  assign rec_time_o = time_q;
  assign rec_byte_o = rd_q;

  always_comb begin
    stats_o = '0;
    stats_o.kind = KIND_STATS;
    stats_o.end_of_run = 1'b1;
    stats_o.entries_now = count_q;
    stats_o.writes_total = writes_q;
    stats_o.drops_total = drops_q;
    stats_o.entries_peak = peak_q;
    stats_o.fill_percent = 7'(prod_q >> AW);
  end
endmodule

// ----- rtl/core/tlrb_ctrl.sv -----
module tlrb_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  tlrb_in_if.sink in_if,
  tlrb_out_if.source out_if,
  output tlrb_pkg::cmd_e cmd_o,
  input  tlrb_pkg::dp_status_t status_i,
  input  logic [31:0] rec_time_i,
  input  logic [7:0] rec_byte_i,
  input  tlrb_pkg::out_word_t stats_i
);
  import tlrb_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EVCHK = 4'd1;
  localparam logic [3:0] S_WR = 4'd2;
  localparam logic [3:0] S_CEND = 4'd3;
  localparam logic [3:0] S_SKIP = 4'd4;
  localparam logic [3:0] S_HDR = 4'd5;
  localparam logic [3:0] S_LEN = 4'd6;
  localparam logic [3:0] S_BYTE = 4'd7;
  localparam logic [3:0] S_MUL = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;

  logic [3:0] state_q, state_d;
  logic ovalid_q, ovalid_d;
  out_word_t odata_q, odata_d;

  assign in_if.ready = (state_q == S_IDLE) && !ovalid_q;
  assign out_if.valid = ovalid_q;
  assign out_if.data = odata_q;

  function automatic out_word_t ack_w(logic [1:0] st);
    out_word_t w;
    w = '0;
    w.kind = KIND_ACK;
    w.status = st;
    w.end_of_run = 1'b1;
    return w;
  endfunction

  logic acc;
  assign acc = in_if.valid && in_if.ready;

  always_comb begin
    state_d = state_q;
    cmd_o = CMD_NONE;
    ovalid_d = ovalid_q && !out_if.ready;
    odata_d = odata_q;
    case (state_q)
      S_IDLE: if (acc) begin
        case (in_if.data.op)
          OP_APPEND: begin
            cmd_o = CMD_STAGE;
            if (in_if.data.last) state_d = S_EVCHK;
            else begin ovalid_d = 1'b1; odata_d = ack_w(ST_OK); end
          end
          OP_POSITION: begin cmd_o = CMD_SKIP_RD; state_d = S_SKIP; end
          OP_READ: begin
            if (status_i.cursor_empty) begin
              ovalid_d = 1'b1; odata_d = ack_w(ST_EMPTY);
            end else begin cmd_o = CMD_POS_SET; state_d = S_HDR; end
          end
          OP_CLEAR: begin
            cmd_o = CMD_CLEAR; ovalid_d = 1'b1; odata_d = ack_w(ST_OK);
          end
          OP_STATS: state_d = S_MUL;
          default: begin ovalid_d = 1'b1; odata_d = ack_w(ST_OK); end
        endcase
      end
      S_EVCHK: begin
        if (status_i.need_evict) cmd_o = CMD_EVICT;
        else if (status_i.fits) state_d = S_WR;
        else state_d = S_CEND;
      end
      S_WR: begin
        cmd_o = CMD_WRITE;
        if (status_i.write_done) state_d = S_CEND;
      end
      S_CEND: begin
        cmd_o = CMD_COMMIT_END;
        ovalid_d = 1'b1;
        odata_d = ack_w(status_i.fits ? ST_OK : ST_FULL);
        state_d = S_IDLE;
      end
      S_SKIP: begin
        if (status_i.no_records) begin
          ovalid_d = 1'b1; odata_d = ack_w(ST_EMPTY); state_d = S_IDLE;
        end else if (status_i.skip_done) begin
          ovalid_d = 1'b1; odata_d = ack_w(ST_OK); state_d = S_IDLE;
        end else begin
          cmd_o = CMD_SKIP;
        end
      end
      S_HDR: begin
        cmd_o = CMD_RD_HDR;
        if (status_i.hdr_done) state_d = S_LEN;
      end
      S_LEN: begin cmd_o = CMD_RD_LEN; state_d = S_BYTE; end
      S_BYTE: begin
        if (status_i.len_zero) begin
          cmd_o = CMD_READ_END;
          ovalid_d = 1'b1; odata_d = ack_w(ST_OK); state_d = S_IDLE;
        end else if (status_i.bytes_done) begin
          cmd_o = CMD_READ_END; state_d = S_IDLE;
        end else if (!ovalid_q || out_if.ready) begin
          cmd_o = CMD_RD_BYTE;
          ovalid_d = 1'b1;
          odata_d = '0;
          odata_d.kind = KIND_BYTE;
          odata_d.rec_time = rec_time_i;
          odata_d.rec_byte = rec_byte_i;
          odata_d.end_of_run = status_i.byte_last;
        end
      end
      S_MUL: state_d = S_OUT;
      S_OUT: begin
        ovalid_d = 1'b1; odata_d = stats_i; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
  end
endmodule

// ----- rtl/core/timestamped_log_ring_buffer_core.sv -----
// Channel  Dir  Payload           Handshake
// in_if    in   in_word_t (op..)  valid/ready
// out_if   out  out_word_t        valid/ready
//
// One word at a time; input ready only when idle with the output register empty.
// Append without last, clear, spare ops: result word the cycle after accept.
// Commit: S_EVCHK evicts as needed, S_WR writes header and message, S_CEND closes.
// Position: S_SKIP steps over one record at a time. Stats: S_MUL, then S_OUT. Read:
// S_HDR takes the timestamp, S_LEN the length, S_BYTE the bytes (output stalls hold
// the walk in place), then a close. Reset clears pointers and counters; the ring
// and staging memories are left uninitialised, only committed bytes are read.
module timestamped_log_ring_buffer_core #(
  parameter int unsigned MSG_MAX = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  tlrb_in_if.sink in_if,
  tlrb_out_if.source out_if
);
  import tlrb_pkg::*;

  cmd_e cmd;
  dp_status_t dp_status;
  logic [31:0] rec_time;
  logic [7:0] rec_byte;
  out_word_t stats;

  tlrb_datapath #(.MSG_MAX(MSG_MAX)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_word_i(in_if.data),
    .status_o(dp_status), .rec_time_o(rec_time), .rec_byte_o(rec_byte),
    .stats_o(stats)
  );

  tlrb_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_if, .out_if, .cmd_o(cmd), .status_i(dp_status),
    .rec_time_i(rec_time), .rec_byte_i(rec_byte), .stats_i(stats)
  );
endmodule

// ----- test/tb_timestamped_log_ring_buffer_core.sv -----
module tb_timestamped_log_ring_buffer_core;
  import tlrb_pkg::*;

  localparam int unsigned RingBytes = 4096;
  localparam int unsigned MsgLimit = 64;
  localparam int unsigned CycleLimit = 1500000;
  localparam logic [2:0] OpSpareLo = 3'd5;
  localparam logic [2:0] OpSpareHi = 3'd7;

  // Software mirror of the log ring plus a queue of expected output words.
  class log_ring_scoreboard;
    byte unsigned ring[RingBytes];
    byte unsigned staged[MsgLimit];
    int unsigned staged_len, head, tail, held, cur_pos, cur_left;
    bit [31:0] writes, drops;
    int unsigned peak;
    out_word_t pending[$];
    int unsigned errors, bytes_seen, records_read, fulls;

    function int unsigned adv(int unsigned p, int unsigned n);
      return (p + n) % RingBytes;
    endfunction

    function int unsigned room();
      if (tail <= head) return RingBytes - (head - tail) - 1;
      return tail - head - 1;
    endfunction

    function int unsigned span(int unsigned p);
      return HdrBytes + ring[adv(p, 4)];
    endfunction

    function void push_ack(logic [1:0] st);
      out_word_t w;
      w = '0;
      w.kind = KIND_ACK;
      w.status = st;
      w.end_of_run = 1'b1;
      pending.push_back(w);
    endfunction

    function logic [1:0] commit_record(logic [31:0] stamp);
      int unsigned need, w;
      need = HdrBytes + staged_len;
      cur_left = 0;
      while (held > 0 && (room() < need || held >= CountLimit)) begin
        tail = adv(tail, span(tail));
        held--;
        drops++;
      end
      if (room() < need) begin
        staged_len = 0;
        fulls++;
        return ST_FULL;
      end
      w = head;
      for (int i = 0; i < 4; i++) begin
        ring[w] = stamp[8*i +: 8];
        w = adv(w, 1);
      end
      ring[w] = staged_len[7:0];
      w = adv(w, 1);
      for (int i = 0; i < staged_len; i++) begin
        ring[w] = staged[i];
        w = adv(w, 1);
      end
      head = w;
      staged_len = 0;
      held++;
      writes++;
      if (held > peak) peak = held;
      return ST_OK;
    endfunction

    function void note_input(in_word_t x);
      out_word_t w;
      int unsigned want, p, len, n;
      logic [31:0] t;
      case (x.op)
        OP_APPEND: begin
          if (staged_len < MsgLimit) begin
            staged[staged_len] = x.data_byte;
            staged_len++;
          end
          if (!x.last) push_ack(ST_OK);
          else push_ack(commit_record(x.time_stamp));
        end
        OP_POSITION: begin
          if (held == 0) begin
            cur_left = 0;
            push_ack(ST_EMPTY);
          end else begin
            want = x.latest_count;
            if (want == 0 || want > held) want = held;
            p = tail;
            for (int i = 0; i < held - want; i++) p = adv(p, span(p));
            cur_pos = p;
            cur_left = want;
            push_ack(ST_OK);
          end
        end
        OP_READ: begin
          if (cur_left == 0) push_ack(ST_EMPTY);
          else begin
            p = cur_pos;
            for (int i = 0; i < 4; i++) begin
              t[8*i +: 8] = ring[p];
              p = adv(p, 1);
            end
            len = ring[p];
            p = adv(p, 1);
            n = (len < MaxResults) ? len : MaxResults;
            for (int i = 0; i < n; i++) begin
              w = '0;
              w.kind = KIND_BYTE;
              w.rec_time = t;
              w.rec_byte = ring[p];
              w.end_of_run = (i + 1 == n);
              pending.push_back(w);
              p = adv(p, 1);
            end
            cur_pos = adv(cur_pos, HdrBytes + len);
            cur_left--;
            records_read++;
            if (n == 0) push_ack(ST_OK);
          end
        end
        OP_CLEAR: begin
          head = 0;
          tail = 0;
          held = 0;
          cur_left = 0;
          push_ack(ST_OK);
        end
        OP_STATS: begin
          w = '0;
          w.kind = KIND_STATS;
          w.end_of_run = 1'b1;
          w.entries_now = held[9:0];
          w.writes_total = writes;
          w.drops_total = drops;
          w.entries_peak = peak[9:0];
          w.fill_percent = 7'(((RingBytes - room() - 1) * 100) / RingBytes);
          pending.push_back(w);
        end
        default: push_ack(ST_OK);
      endcase
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      bytes_seen++;
      if (pending.size() == 0) begin
        $error("unexpected output word %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.kind !== e.kind) begin
        $error("kind exp %0d got %0d", e.kind, got.kind); errors++;
      end
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.rec_time !== e.rec_time) begin
        $error("rec_time exp %h got %h", e.rec_time, got.rec_time); errors++;
      end
      if (got.rec_byte !== e.rec_byte) begin
        $error("rec_byte exp %h got %h", e.rec_byte, got.rec_byte); errors++;
      end
      if (got.end_of_run !== e.end_of_run) begin
        $error("end_of_run exp %0d got %0d", e.end_of_run, got.end_of_run); errors++;
      end
      if (got.entries_now !== e.entries_now) begin
        $error("entries_now exp %0d got %0d", e.entries_now, got.entries_now); errors++;
      end
      if (got.writes_total !== e.writes_total) begin
        $error("writes_total exp %0d got %0d", e.writes_total, got.writes_total);
        errors++;
      end
      if (got.drops_total !== e.drops_total) begin
        $error("drops_total exp %0d got %0d", e.drops_total, got.drops_total); errors++;
      end
      if (got.entries_peak !== e.entries_peak) begin
        $error("entries_peak exp %0d got %0d", e.entries_peak, got.entries_peak);
        errors++;
      end
      if (got.fill_percent !== e.fill_percent) begin
        $error("fill_percent exp %0d got %0d", e.fill_percent, got.fill_percent);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned cycles = 0;
  bit rx_on = 1'b0;
  int unsigned sent = 0;

  tlrb_in_if in_ch();
  tlrb_out_if out_ch();
  log_ring_scoreboard sb = new();

  timestamped_log_ring_buffer_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one, sometimes none at all.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Scoreboard sees results at the rising edge; ready toggles on the falling one.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned g;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_on) begin
        g = gap_len();
        if (g > 0) begin
          out_ch.ready <= 1'b0;
          repeat (g - 1) @(negedge clk_i);
          @(negedge clk_i);
        end
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Leaves valid high after the accept; the next word or gap replaces it.
  task automatic send_word(in_word_t x);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_ch.data <= x;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(x);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send_op(op_e op, logic [7:0] b, logic l, logic [31:0] ts,
                         logic [9:0] lc);
    in_word_t x;
    x.op = op;
    x.data_byte = b;
    x.last = l;
    x.time_stamp = ts;
    x.latest_count = lc;
    send_word(x);
  endtask

  // One message of n bytes (n >= 1), random content.
  task automatic send_msg(int unsigned n);
    for (int i = 0; i < n; i++)
      send_op(OP_APPEND, 8'($urandom), i == n - 1, $urandom, 10'($urandom));
  endtask

  initial begin
    in_word_t x;
    int unsigned r;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    rx_on = 1'b1;

    // Directed: empty reads, extreme fields, truncation, spare ops, clear.
    send_op(OP_POSITION, 8'h00, 1'b0, 32'h0, 10'd0);
    send_op(OP_READ, 8'hff, 1'b1, 32'hffff_ffff, 10'h3ff);
    send_op(OP_STATS, 8'h00, 1'b0, 32'h0, 10'd0);
    send_op(OP_APPEND, 8'hff, 1'b1, 32'hffff_ffff, 10'h3ff);
    send_op(OP_APPEND, 8'h00, 1'b1, 32'h0000_0000, 10'h000);
    for (int i = 0; i < 66; i++)
      send_op(OP_APPEND, 8'(i * 37), i == 65, 32'hdead_beef, 10'h155);
    send_op(OP_POSITION, 8'h00, 1'b0, 32'h0, 10'h3ff);
    repeat (4) send_op(OP_READ, 8'h00, 1'b0, 32'h0, 10'd0);
    send_op(OP_POSITION, 8'h00, 1'b0, 32'h0, 10'd1);
    send_op(OP_READ, 8'h00, 1'b0, 32'h0, 10'd0);
    x = '0; x.op = OpSpareLo; send_word(x);
    x.op = OpSpareHi; send_word(x);
    send_op(OP_STATS, 8'h00, 1'b0, 32'h0, 10'd0);
    send_op(OP_CLEAR, 8'h00, 1'b0, 32'h0, 10'd0);
    send_op(OP_READ, 8'h00, 1'b0, 32'h0, 10'd0);
    send_op(OP_STATS, 8'h00, 1'b0, 32'h0, 10'd0);

    // Random: short messages, positioning and readouts.
    while (sent < 124) begin
      r = $urandom_range(0, 99);
      if (r < 45) send_msg($urandom_range(1, 6));
      else if (r < 60) send_op(OP_POSITION, 8'($urandom), 1'($urandom), $urandom,
                               $urandom_range(0, 3) == 0 ? 10'($urandom)
                                                         : 10'($urandom_range(0, 6)));
      else if (r < 85) send_op(OP_READ, 8'($urandom), 1'($urandom), $urandom,
                               10'($urandom));
      else if (r < 92) send_op(OP_STATS, 8'($urandom), 1'($urandom), $urandom,
                               10'($urandom));
      else if (r < 96) begin
        x = '0;
        x.op = 3'($urandom_range(OpSpareLo, OpSpareHi));
        x.time_stamp = $urandom;
        send_word(x);
      end else send_op(OP_CLEAR, 8'($urandom), 1'($urandom), $urandom, 10'($urandom));
    end

    send_op(OP_POSITION, 8'h00, 1'b0, 32'h0, 10'd3);
    repeat (3) send_op(OP_READ, 8'h00, 1'b0, 32'h0, 10'd0);
    send_op(OP_STATS, 8'h00, 1'b0, 32'h0, 10'd0);
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Sent %0d input words, checked %0d output words, %0d records read back,",
             sent, sb.bytes_seen, sb.records_read);
    $display("%0d commits, %0d evictions, %0d full rejects.", sb.writes, sb.drops,
             sb.fulls);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/tlrb_pkg.sv
rtl/core/tlrb_if.sv
rtl/core/tlrb_datapath.sv
rtl/core/tlrb_ctrl.sv
rtl/core/timestamped_log_ring_buffer_core.sv
test/tb_timestamped_log_ring_buffer_core.sv
